FILE: rtl/core/windowed_2d_fenwick_max_assert.svh
// Assertion macros for the fenwick max block.
`ifndef WINDOWED_2D_FENWICK_MAX_ASSERT_SVH
`define WINDOWED_2D_FENWICK_MAX_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define W2FM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("w2fm assertion failed");

// Check an implication on every clock edge outside reset.
`define W2FM_ASSERT_IMP(name, ante, cons) \
  `W2FM_ASSERT(name, (ante) |-> (cons))

`endif

FILE: rtl/core/w2fm_pkg.sv
`timescale 1ns / 1ps
package w2fm_pkg;

  localparam int SIDE    = 256;
  localparam int IDX_W   = $clog2(SIDE);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = SIDE * SIDE;
  localparam int COORD_W = 9;
  localparam int VAL_W   = 31;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam int WALK_W  = COORD_W + 1;
  localparam int CMP_W   = WALK_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'b1;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [CFG_W-1:0] GRID_RESET   = CFG_W'(256);
  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } seq_state_e;

  function automatic logic [WALK_W-1:0] low_bit(logic [WALK_W-1:0] x);
    return x & (~x + 1'b1);
  endfunction

  function automatic logic walk_ok(logic cmd, logic [WALK_W-1:0] x,
                                   logic [WALK_W-1:0] start, logic [CFG_W-1:0] n,
                                   logic [CFG_W-1:0] k);
    logic [CMP_W-1:0] xe;
    logic [CMP_W-1:0] se;
    logic [CMP_W-1:0] ne;
    logic [CMP_W-1:0] ke;
    logic ok;
    xe = CMP_W'(x);
    se = CMP_W'(start);
    ne = CMP_W'(n);
    ke = CMP_W'(k);
    if (cmd == CMD_UPDATE) begin
      ok = (x != '0) && (xe <= ne) && (xe < se + ke);
    end else begin
      ok = (x != '0) && (xe + ke > se);
    end
    return ok;
  endfunction

  function automatic logic in_range(logic [WALK_W-1:0] x);
    return (x != '0) && (x <= WALK_W'(SIDE));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [WALK_W-1:0] r,
                                                  logic [WALK_W-1:0] c);
    logic [WALK_W-1:0] rm;
    logic [WALK_W-1:0] cm;
    rm = r - 1'b1;
    cm = c - 1'b1;
    return {rm[IDX_W-1:0], cm[IDX_W-1:0]};
  endfunction

endpackage

FILE: rtl/core/w2fm_if.sv
`timescale 1ns / 1ps
interface w2fm_in_if import w2fm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [VAL_W-1:0]   value;
  modport source(output valid, cmd, row, col, value, input ready);
  modport sink(input valid, cmd, row, col, value, output ready);
endinterface

interface w2fm_out_if import w2fm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] max_value;
  modport source(output valid, max_value, input ready);
  modport sink(input valid, max_value, output ready);
endinterface

interface w2fm_cfg_if import w2fm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/w2fm_ram.sv
`timescale 1ns / 1ps
module w2fm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/windowed_2d_fenwick_max.sv
`timescale 1ns / 1ps
// Sequencing: a query walks its path cells, drains the last read, then raises its result valid;
// an empty query goes straight to its result; an update walks any path cells, drains, then idles.
// Throughput: one item at a time; a new item is taken only once the last one is back in idle;
// up to 81 cells for a 256 grid, at most one tree memory read per cycle. A result waits in an output
// register and stalls input only when the next query reaches its result.
// Reset: asynchronous, active low; state, clear counter, valid flags and config take reset values,
// then a clearing pass zeroes every tree memory entry, during which no item is taken.
module windowed_2d_fenwick_max import w2fm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  w2fm_cfg_if.sink     cfg_i,
  w2fm_in_if.sink      in_i,
  w2fm_out_if.source   out_o
);

  seq_state_e         state_q, state_d;
  logic [CFG_W-1:0]   grid_q, win_q;
  logic [CFG_W-1:0]   grid_eff;
  logic               cmd_q, cmd_d;
  logic [COORD_W-1:0] row_q, row_d, col_q, col_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [WALK_W-1:0]  r_q, r_d, c_q, c_d;
  logic [WALK_W-1:0]  step_r, step_c;
  logic               r_more, c_more, start_ok;
  logic [VAL_W-1:0]   best_q, best_d;
  logic               p_valid_q, p_valid_d;
  logic               p_inr_q, p_inr_d;
  logic [ADDR_W-1:0]  p_addr_q, p_addr_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [VAL_W-1:0]   out_data_q, out_data_d;
  logic               in_accept;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic [VAL_W-1:0]   mem_rdata;
  logic [VAL_W-1:0]   rd_val;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
      win_q  <= WINDOW_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_GRID_SIZE: grid_q <= cfg_i.data;
        REG_WINDOW:    win_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign grid_eff = (grid_q > CFG_W'(SIDE)) ? CFG_W'(SIDE) : grid_q;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign step_c = (cmd_q == CMD_UPDATE) ? c_q + low_bit(c_q) : c_q - low_bit(c_q);
  assign step_r = (cmd_q == CMD_UPDATE) ? r_q + low_bit(r_q) : r_q - low_bit(r_q);
  assign c_more = walk_ok(cmd_q, step_c, WALK_W'(col_q), grid_eff, win_q);
  assign r_more = walk_ok(cmd_q, step_r, WALK_W'(row_q), grid_eff, win_q);
  assign start_ok =
      walk_ok(in_i.cmd, WALK_W'(in_i.row), WALK_W'(in_i.row), grid_eff, win_q) &&
      walk_ok(in_i.cmd, WALK_W'(in_i.col), WALK_W'(in_i.col), grid_eff, win_q);

  assign rd_addr   = cell_addr(r_q, c_q);
  assign p_inr_d   = in_range(r_q) && in_range(c_q);
  assign rd_en     = (state_q == S_WALK) && p_inr_d;
  assign p_valid_d = (state_q == S_WALK);
  assign p_addr_d  = rd_addr;

  assign rd_val = p_inr_q ? mem_rdata : '0;

  always_comb begin
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = p_valid_q && (cmd_q == CMD_UPDATE) && (mem_rdata < val_q);
      mem_waddr = p_addr_q;
      mem_wdata = val_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    val_d       = val_q;
    r_d         = r_q;
    c_d         = c_q;
    clr_d       = clr_q;
    best_d      = best_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (p_valid_q && (cmd_q == CMD_QUERY) && (rd_val > best_q)) begin
      best_d = rd_val;
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {ADDR_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd_d  = in_i.cmd;
          row_d  = in_i.row;
          col_d  = in_i.col;
          val_d  = in_i.value;
          r_d    = WALK_W'(in_i.row);
          c_d    = WALK_W'(in_i.col);
          best_d = '0;
          if (start_ok) begin
            state_d = S_WALK;
          end else if (in_i.cmd == CMD_QUERY) begin
            state_d = S_RESULT;
          end else begin
            state_d = S_DRAIN;
          end
        end
      end
      S_WALK: begin
        if (c_more) begin
          c_d = step_c;
        end else if (r_more) begin
          r_d = step_r;
          c_d = WALK_W'(col_q);
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (cmd_q == CMD_QUERY) ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = best_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    r_q        <= r_d;
    c_q        <= c_d;
    best_q     <= best_d;
    p_inr_q    <= p_inr_d;
    p_addr_q   <= p_addr_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.max_value = out_data_q;

  w2fm_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_tree (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(mem_rdata)
  );

`include "windowed_2d_fenwick_max_assert.svh"

  `W2FM_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != S_IDLE))
  `W2FM_ASSERT_IMP(a_stage_from_walk, p_valid_q, $past(state_q) == S_WALK)
  `W2FM_ASSERT_IMP(a_clear_full_sweep, (state_q == S_IDLE) && ($past(state_q) == S_CLEAR),
                   $past(clr_q) == {ADDR_W{1'b1}})
  `W2FM_ASSERT_IMP(a_result_from_seq, $rose(out_valid_q), $past(state_q) == S_RESULT)

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import w2fm_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [VAL_W-1:0]   value;
  } fen_item_t;

  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 3000;
  localparam int PHASE_ITEMS   = 150;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  logic clk_i;
  logic rst_ni;

  w2fm_cfg_if cfg_if ();
  w2fm_in_if  in_if ();
  w2fm_out_if out_if ();

  windowed_2d_fenwick_max u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [VAL_W-1:0] fen_tree [DEPTH];
  logic [CFG_W-1:0] grid_m;
  logic [CFG_W-1:0] window_m;
  logic [VAL_W-1:0] max_expect_q [$];

  int gap_max;
  int stall_max;
  bit long_hold_req;
  int n_updates;
  int n_queries;
  int n_checked;
  int n_writes;
  int n_errors;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int lowbit(int x);
    return x & -x;
  endfunction

  function automatic int grid_eff();
    return (grid_m > SIDE) ? SIDE : int'(grid_m);
  endfunction

  function automatic void raise_fenwick(int row, int col, logic [VAL_W-1:0] v);
    int n;
    int k;
    int r;
    int c;
    n = grid_eff();
    k = window_m;
    if (row < 1 || col < 1) return;
    for (r = row; r <= row + k - 1 && r <= n; r += lowbit(r))
      for (c = col; c <= col + k - 1 && c <= n; c += lowbit(c))
        if (fen_tree[(r - 1) * SIDE + c - 1] < v) fen_tree[(r - 1) * SIDE + c - 1] = v;
  endfunction

  function automatic logic [VAL_W-1:0] query_fenwick(int row, int col);
    int k;
    int r;
    int c;
    logic [VAL_W-1:0] best;
    k = window_m;
    best = '0;
    for (r = row; r >= row - k + 1 && r > 0; r -= lowbit(r))
      for (c = col; c >= col - k + 1 && c > 0; c -= lowbit(c))
        if (r <= SIDE && c <= SIDE && fen_tree[(r - 1) * SIDE + c - 1] > best)
          best = fen_tree[(r - 1) * SIDE + c - 1];
    return best;
  endfunction

  function automatic void predict(fen_item_t it);
    if (it.cmd == CMD_UPDATE) begin
      raise_fenwick(it.row, it.col, it.value);
      n_updates++;
    end else begin
      max_expect_q = {max_expect_q, query_fenwick(it.row, it.col)};
      n_queries++;
    end
  endfunction

  function automatic fen_item_t mk_item(logic cmd, int row, int col, logic [VAL_W-1:0] v);
    fen_item_t it;
    it.cmd   = cmd;
    it.row   = COORD_W'(row);
    it.col   = COORD_W'(col);
    it.value = v;
    return it;
  endfunction

  function automatic fen_item_t rand_item(int query_pct);
    fen_item_t it;
    int n;
    n = grid_eff();
    if (n < 1) n = 1;
    it.cmd = ($urandom_range(0, 99) < query_pct) ? CMD_QUERY : CMD_UPDATE;
    if ($urandom_range(0, 19) == 0) begin
      it.row = COORD_W'($urandom);
      it.col = COORD_W'($urandom);
    end else begin
      it.row = COORD_W'($urandom_range(1, n));
      it.col = COORD_W'($urandom_range(1, n));
    end
    if ($urandom_range(0, 3) == 0) it.value = VAL_W'($urandom_range(0, 15));
    else it.value = VAL_W'($urandom);
    return it;
  endfunction

  task automatic send_item(fen_item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.cmd   <= it.cmd;
    in_if.row   <= it.row;
    in_if.col   <= it.col;
    in_if.value <= it.value;
    do @(posedge clk_i); while (!in_if.ready);
    predict(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_GRID_SIZE) grid_m = val;
    else window_m = val;
    n_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (max_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    write_reg(REG_GRID_SIZE, CFG_W'(256));
    write_reg(REG_WINDOW, CFG_W'(256));
    send_item(mk_item(CMD_QUERY, 1, 1, VAL_MAX));
    send_item(mk_item(CMD_UPDATE, 256, 256, VAL_MAX));
    send_item(mk_item(CMD_UPDATE, 1, 1, 5));
    send_item(mk_item(CMD_UPDATE, 128, 3, 0));
    send_item(mk_item(CMD_QUERY, 256, 256, 0));
    send_item(mk_item(CMD_QUERY, 1, 1, 0));
    send_item(mk_item(CMD_QUERY, 511, 511, 0));
    send_item(mk_item(CMD_QUERY, 0, 7, 0));
    send_item(mk_item(CMD_QUERY, 7, 0, 0));
    send_item(mk_item(CMD_UPDATE, 0, 9, 100));
    send_item(mk_item(CMD_UPDATE, 9, 0, 100));
    send_item(mk_item(CMD_UPDATE, 300, 2, 77));
    send_item(mk_item(CMD_QUERY, 255, 255, 0));
    settle();
    // zero window: walks are empty in both directions
    write_reg(REG_WINDOW, CFG_W'(0));
    send_item(mk_item(CMD_UPDATE, 2, 2, 999));
    send_item(mk_item(CMD_QUERY, 2, 2, 0));
    settle();
    write_reg(REG_WINDOW, CFG_W'(256));
    write_reg(REG_GRID_SIZE, CFG_W'(0));
    send_item(mk_item(CMD_UPDATE, 4, 4, 1234));
    send_item(mk_item(CMD_QUERY, 4, 4, 0));
    settle();
    write_reg(REG_GRID_SIZE, CFG_W'(300));
    send_item(mk_item(CMD_UPDATE, 256, 1, 42));
    send_item(mk_item(CMD_QUERY, 256, 256, 0));
    settle();
    write_reg(REG_GRID_SIZE, CFG_W'(1));
    send_item(mk_item(CMD_UPDATE, 1, 1, 9));
    send_item(mk_item(CMD_UPDATE, 2, 1, 8));
    send_item(mk_item(CMD_QUERY, 2, 2, 0));
    settle();
  endtask

  task automatic test_random_walks();
    int grid_tab [6] = '{256, 256, 1, 16, 37, 0};
    int win_tab [6] = '{256, 1, 256, 4, 9, 0};
    int p;
    int i;
    for (p = 0; p < 6; p++) begin
      if (p == 5) begin
        grid_tab[p] = $urandom_range(1, 256);
        win_tab[p] = $urandom_range(1, 256);
      end
      write_reg(REG_GRID_SIZE, CFG_W'(grid_tab[p]));
      write_reg(REG_WINDOW, CFG_W'(win_tab[p]));
      gap_max = (p == 2) ? 0 : 17;
      stall_max = (p == 2) ? 0 : 17;
      for (i = 0; i < PHASE_ITEMS; i++) send_item(rand_item(45));
      settle();
    end
    gap_max = 17;
    stall_max = 17;
  endtask

  task automatic test_backpressure();
    int i;
    write_reg(REG_GRID_SIZE, CFG_W'(64));
    write_reg(REG_WINDOW, CFG_W'(64));
    gap_max = 3;
    long_hold_req = 1'b1;
    for (i = 0; i < 40; i++) send_item(rand_item(80));
    settle();
    gap_max = 17;
  endtask

  always @(posedge clk_i) begin : check_results
    logic [VAL_W-1:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      n_checked++;
      if (max_expect_q.size() == 0) begin
        n_errors++;
        $error("max_value unexpected beat: expected none, actual %0d", out_if.max_value);
      end else begin
        want = max_expect_q.pop_front();
        if (out_if.max_value !== want) begin
          n_errors++;
          $error("max_value mismatch: expected %0d, actual %0d", want, out_if.max_value);
        end
      end
    end
  end

  initial begin : drain_results
    int n;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold_req) begin
        n = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, stall_max);
      end
      repeat (n) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("FAIL windowed_2d_fenwick_max");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_UPDATE;
    in_if.row = '0;
    in_if.col = '0;
    in_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GRID_SIZE;
    cfg_if.data = '0;
    gap_max = 17;
    stall_max = 17;
    long_hold_req = 1'b0;
    grid_m = GRID_RESET;
    window_m = WINDOW_RESET;
    foreach (fen_tree[i]) fen_tree[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_walks();
    test_backpressure();

    $display("Run covered %0d updates and %0d queries, %0d result beats checked.",
             n_updates, n_queries, n_checked);
    $display("%0d register writes across grid and window extremes, %0d mismatches.",
             n_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS windowed_2d_fenwick_max");
    end else begin
      $display("FAIL windowed_2d_fenwick_max");
    end
    $finish;
  end

endmodule
